/* sv/bfd_pkg.sv */
package bfd_pkg;

    localparam int NCHAN     = 4;
    localparam int HALF_DIV  = 2;
    localparam int BYTE_W    = 8;
    localparam int SUM_W     = 36;
    localparam int CNT_W     = 29;
    localparam int DIM_W     = 15;
    localparam int POS_W     = 14;
    localparam int OW_W      = 12;
    localparam int MAX_OW    = 2048;
    localparam int MAX_SRC   = 16384;
    localparam int COL_W     = $clog2(MAX_OW);
    localparam int MEAN_W    = SUM_W + 1;
    localparam int STEP_W    = $clog2(BYTE_W);
    localparam int DSTEP_W   = $clog2(DIM_W);
    localparam int IDX_W     = 2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [IDX_W-1:0] {
        REG_SRC_W = 2'd0,
        REG_SRC_H = 2'd1,
        REG_OUT_W = 2'd2,
        REG_OUT_H = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_CFG,
        S_INIT,
        S_IDLE,
        S_RMW,
        S_MEAN
    } state_t;

    typedef struct packed {
        sum_t [NCHAN-1:0] sum;
        cnt_t             cnt;
    } acc_entry_t;

    typedef struct packed {
        logic             rd_en;
        logic             upd_en;
        logic             first;
        logic [COL_W-1:0] addr;
    } acc_ctrl_t;

endpackage

/* sv/bfd_if.sv */
interface bfd_pix_if;
    import bfd_pkg::*;
    logic  valid;
    logic  ready;
    byte_t chan0;
    byte_t chan1;
    byte_t chan2;
    byte_t chan3;
    modport source (output valid, chan0, chan1, chan2, chan3, input ready);
    modport sink   (input valid, chan0, chan1, chan2, chan3, output ready);
endinterface

interface bfd_avg_if;
    import bfd_pkg::*;
    logic  valid;
    logic  ready;
    byte_t avg0;
    byte_t avg1;
    byte_t avg2;
    byte_t avg3;
    logic  frame_end;
    modport source (output valid, avg0, avg1, avg2, avg3, frame_end, input ready);
    modport sink   (input valid, avg0, avg1, avg2, avg3, frame_end, output ready);
endinterface

/* sv/bfd_cdiv.sv */
module bfd_cdiv (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bfd_pkg::DIM_W-1:0] num,
    input  logic [bfd_pkg::DIM_W-1:0] den,
    output logic [bfd_pkg::DIM_W-1:0] quo,
    output logic [bfd_pkg::DIM_W-1:0] rem,
    output logic                      done
);
    import bfd_pkg::*;

    logic [DIM_W:0]     rem_reg, rem_next;
    logic [DIM_W-1:0]   num_reg, num_next;
    logic [DIM_W-1:0]   den_reg;
    logic [DSTEP_W-1:0] step_reg;
    logic               busy_reg;
    logic [DIM_W:0]     shifted;
    logic               ge;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        shifted  = {rem_reg[DIM_W-1:0], num_reg[DIM_W-1]};
        ge       = shifted >= {1'b0, den_reg};
        rem_next = ge ? shifted - {1'b0, den_reg} : shifted;
        num_next = {num_reg[DIM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == DSTEP_W'(DIM_W - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            num_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
        end
    end

    assign quo  = num_reg;
    assign rem  = rem_reg[DIM_W-1:0];
    assign done = !busy_reg;

endmodule

/* sv/bfd_acc.sv */
module bfd_acc (
    input  logic                                      clk,
    input  bfd_pkg::acc_ctrl_t                        ctrl,
    input  bfd_pkg::byte_t [bfd_pkg::NCHAN-1:0]       pix,
    output bfd_pkg::acc_entry_t                       upd
);
    import bfd_pkg::*;

    acc_entry_t       mem [MAX_OW];
    acc_entry_t       rd_reg;
    logic [COL_W-1:0] addr_reg;

    // first pixel of a box overwrites, the rest accumulate
    always_comb
    begin
        for (int ch = 0; ch < NCHAN; ch++)
        begin
            if (ctrl.first)
                upd.sum[ch] = SUM_W'(pix[ch]);
            else
                upd.sum[ch] = rd_reg.sum[ch] + SUM_W'(pix[ch]);
        end
        upd.cnt = ctrl.first ? CNT_W'(1) : rd_reg.cnt + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_reg   <= mem[ctrl.addr];
            addr_reg <= ctrl.addr;
        end
        if (ctrl.upd_en)
            mem[addr_reg] <= upd;
    end

endmodule

/* sv/bfd_mean.sv */
module bfd_mean (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  bfd_pkg::acc_entry_t                 entry,
    output bfd_pkg::byte_t [bfd_pkg::NCHAN-1:0] quo,
    output logic                                done
);
    import bfd_pkg::*;

    logic [NCHAN-1:0][MEAN_W-1:0] rem_reg;
    cnt_t                         cnt_reg;
    byte_t [NCHAN-1:0]            quo_reg;
    logic [STEP_W-1:0]            step_reg;
    logic                         busy_reg;
    logic [MEAN_W-1:0]            dsh;

    // mean never exceeds 255, so eight quotient bits suffice
    assign dsh = MEAN_W'(cnt_reg) << step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(BYTE_W - 1);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == '0)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cnt_reg <= entry.cnt;
            quo_reg <= '0;
            for (int ch = 0; ch < NCHAN; ch++)
                rem_reg[ch] <= MEAN_W'(entry.sum[ch]) + MEAN_W'(entry.cnt / HALF_DIV);
        end
        else if (busy_reg)
        begin
            for (int ch = 0; ch < NCHAN; ch++)
            begin
                if (rem_reg[ch] >= dsh)
                begin
                    rem_reg[ch]           <= rem_reg[ch] - dsh;
                    quo_reg[ch][step_reg] <= 1'b1;
                end
            end
        end
    end

    assign quo  = quo_reg;
    assign done = !busy_reg;

endmodule

/* sv/box_filter_image_downscaler.sv */
// Box-filter downscaler, area average of four 8-bit channels.
// pix: source pixels in raster order, valid/ready; a request is taken on
// valid && ready. avg: one output pixel per completed box, frame_end set on
// the last output pixel of the image.
// Configuration: cfg_we/cfg_index/cfg_data writes the source row length (0),
// source row count (1), output row length (2) and output row count (3). Any
// write restarts the frame and runs the box-step divisions, with pix.ready low
// meanwhile; write only while the block is idle.
// Each request reads the column's sums from the accumulator memory, then
// updates them and writes them back. A request that closes a box then runs
// the eight-step rounded-mean division, and no new request is taken until
// the previous one is through. After the closing request the block passes
// S_RMW and S_MEAN; avg.valid comes from out_valid_reg once the mean is done.
// Reset: registers take 2, 2, 1, 1 and the frame restarts; the memory is
// not cleared, as every box overwrites its entry on its first pixel.
// A stalled output holds in its register; a further finished mean waits in
// the divider until that register is free, and no request is taken meanwhile.
module box_filter_image_downscaler (
    input  logic                                clk,
    input  logic                                rst_n,
    bfd_pix_if.sink                             pix,
    bfd_avg_if.source                           avg,
    input  logic                                cfg_we,
    input  logic [bfd_pkg::IDX_W-1:0]           cfg_index,
    input  logic [bfd_pkg::DIM_W-1:0]           cfg_data
);
    import bfd_pkg::*;

    state_t            state_reg, state_next;
    logic [DIM_W-1:0]  sw_reg, sw_next, sh_reg, sh_next, oh_reg, oh_next;
    logic [OW_W-1:0]   ow_reg, ow_next;
    logic [DIM_W-1:0]  cq_reg, cq_next, rq_reg, rq_next, rr_reg, rr_next;
    logic [OW_W-1:0]   cr_reg, cr_next;
    logic [POS_W-1:0]  src_col_reg, src_col_next, src_row_reg, src_row_next;
    logic [POS_W-1:0]  dst_row_reg, dst_row_next;
    logic [COL_W-1:0]  dst_col_reg, dst_col_next;
    logic [DIM_W-1:0]  col_start_reg, col_start_next, col_edge_reg, col_edge_next;
    logic [OW_W-1:0]   crem_reg, crem_next;
    logic [DIM_W-1:0]  row_edge_reg, row_edge_next, rrem_reg, rrem_next;
    logic              first_row_reg, first_row_next;
    logic              is_first_reg, is_first_next, emit_reg, emit_next;
    logic              fend_reg, fend_next;
    byte_t [NCHAN-1:0] pix_reg, pix_next;
    logic              out_valid_reg, out_valid_next, out_fend_reg, out_fend_next;
    byte_t [NCHAN-1:0] avg_reg, avg_next;

    logic [DIM_W-1:0]  sw_eff, sh_eff, oh_eff;
    logic [OW_W-1:0]   ow_eff, ow_lim;
    logic              accept, last_col, last_row, row_end, frame_last, slot_free;
    logic [OW_W:0]     col_sum;
    logic              col_wrap;
    logic [DIM_W:0]    row_sum;
    logic              row_wrap;
    logic [DIM_W-1:0]  col_edge_adv, row_edge_adv;
    logic [OW_W-1:0]   crem_adv;
    logic [DIM_W-1:0]  rrem_adv;

    acc_ctrl_t         acc_ctrl;
    acc_entry_t        acc_upd;
    logic              mean_start, mean_done, div_start, cdiv_done, rdiv_done;
    byte_t [NCHAN-1:0] mean_q;
    logic [DIM_W-1:0]  cdiv_q, cdiv_r, rdiv_q, rdiv_r;

    // sizes as used: zero taken as one, output never wider than source
    always_comb
    begin
        sw_eff = (sw_reg == '0) ? DIM_W'(1) : (sw_reg > DIM_W'(MAX_SRC)) ? DIM_W'(MAX_SRC) : sw_reg;
        sh_eff = (sh_reg == '0) ? DIM_W'(1) : (sh_reg > DIM_W'(MAX_SRC)) ? DIM_W'(MAX_SRC) : sh_reg;
        ow_lim = (sw_eff < DIM_W'(MAX_OW)) ? sw_eff[OW_W-1:0] : OW_W'(MAX_OW);
        ow_eff = (ow_reg == '0) ? OW_W'(1) : (ow_reg > ow_lim) ? ow_lim : ow_reg;
        oh_eff = (oh_reg == '0) ? DIM_W'(1) : (oh_reg > sh_eff) ? sh_eff : oh_reg;
    end

    // box edges step by quotient plus a carry from the remainder sum
    always_comb
    begin
        accept       = pix.valid && pix.ready;
        slot_free    = !out_valid_reg || avg.ready;
        last_col     = (DIM_W'(src_col_reg) + 1'b1) == col_edge_reg;
        last_row     = (DIM_W'(src_row_reg) + 1'b1) == row_edge_reg;
        row_end      = (DIM_W'(src_col_reg) + 1'b1) == sw_eff;
        frame_last   = row_end && ((DIM_W'(src_row_reg) + 1'b1) == sh_eff);
        col_sum      = {1'b0, crem_reg} + {1'b0, cr_reg};
        col_wrap     = col_sum >= {1'b0, ow_eff};
        crem_adv     = OW_W'(col_wrap ? col_sum - {1'b0, ow_eff} : col_sum);
        col_edge_adv = col_edge_reg + cq_reg + DIM_W'(col_wrap);
        row_sum      = {1'b0, rrem_reg} + {1'b0, rr_reg};
        row_wrap     = row_sum >= {1'b0, oh_eff};
        rrem_adv     = DIM_W'(row_wrap ? row_sum - {1'b0, oh_eff} : row_sum);
        row_edge_adv = row_edge_reg + rq_reg + DIM_W'(row_wrap);
    end

    always_comb
    begin
        state_next     = state_reg;
        sw_next        = sw_reg;
        sh_next        = sh_reg;
        ow_next        = ow_reg;
        oh_next        = oh_reg;
        cq_next        = cq_reg;
        cr_next        = cr_reg;
        rq_next        = rq_reg;
        rr_next        = rr_reg;
        src_col_next   = src_col_reg;
        src_row_next   = src_row_reg;
        dst_col_next   = dst_col_reg;
        dst_row_next   = dst_row_reg;
        col_start_next = col_start_reg;
        col_edge_next  = col_edge_reg;
        crem_next      = crem_reg;
        row_edge_next  = row_edge_reg;
        rrem_next      = rrem_reg;
        first_row_next = first_row_reg;
        is_first_next  = is_first_reg;
        emit_next      = emit_reg;
        fend_next      = fend_reg;
        pix_next       = pix_reg;
        out_valid_next = out_valid_reg;
        out_fend_next  = out_fend_reg;
        avg_next       = avg_reg;
        acc_ctrl       = '0;
        mean_start     = 1'b0;
        div_start      = 1'b0;
        pix.ready      = (state_reg == S_IDLE) && !cfg_we;

        if (avg.valid && avg.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_CFG:
            begin
                div_start  = 1'b1;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                if (cdiv_done && rdiv_done)
                begin
                    cq_next       = cdiv_q;
                    cr_next       = cdiv_r[OW_W-1:0];
                    rq_next       = rdiv_q;
                    rr_next       = rdiv_r;
                    col_edge_next = cdiv_q;
                    crem_next     = cdiv_r[OW_W-1:0];
                    row_edge_next = rdiv_q;
                    rrem_next     = rdiv_r;
                    state_next    = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    pix_next       = {pix.chan3, pix.chan2, pix.chan1, pix.chan0};
                    is_first_next  = first_row_reg && (DIM_W'(src_col_reg) == col_start_reg);
                    emit_next      = last_col && last_row;
                    fend_next      = ((OW_W'(dst_col_reg) + 1'b1) == ow_eff)
                                     && ((DIM_W'(dst_row_reg) + 1'b1) == oh_eff);
                    acc_ctrl.rd_en = 1'b1;
                    acc_ctrl.addr  = dst_col_reg;
                    state_next     = S_RMW;

                    if (last_col)
                    begin
                        dst_col_next   = dst_col_reg + 1'b1;
                        col_start_next = col_edge_reg;
                        col_edge_next  = col_edge_adv;
                        crem_next      = crem_adv;
                    end
                    src_col_next = src_col_reg + 1'b1;
                    if (row_end)
                    begin
                        src_col_next   = '0;
                        dst_col_next   = '0;
                        col_start_next = '0;
                        col_edge_next  = cq_reg;
                        crem_next      = cr_reg;
                        src_row_next   = src_row_reg + 1'b1;
                        if (last_row)
                        begin
                            dst_row_next   = dst_row_reg + 1'b1;
                            row_edge_next  = row_edge_adv;
                            rrem_next      = rrem_adv;
                            first_row_next = 1'b1;
                        end
                        else
                            first_row_next = 1'b0;
                        if (frame_last)
                        begin
                            src_row_next   = '0;
                            dst_row_next   = '0;
                            row_edge_next  = rq_reg;
                            rrem_next      = rr_reg;
                            first_row_next = 1'b1;
                        end
                    end
                end
            end
            S_RMW:
            begin
                acc_ctrl.upd_en = 1'b1;
                acc_ctrl.first  = is_first_reg;
                if (emit_reg)
                begin
                    mean_start = 1'b1;
                    state_next = S_MEAN;
                end
                else
                    state_next = S_IDLE;
            end
            S_MEAN:
            begin
                if (mean_done && slot_free)
                begin
                    out_valid_next = 1'b1;
                    avg_next       = mean_q;
                    out_fend_next  = fend_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_CFG;
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                REG_SRC_W: sw_next = cfg_data;
                REG_SRC_H: sh_next = cfg_data;
                REG_OUT_W: ow_next = cfg_data[OW_W-1:0];
                REG_OUT_H: oh_next = cfg_data;
                default:   sw_next = sw_reg;
            endcase
            src_col_next   = '0;
            src_row_next   = '0;
            dst_col_next   = '0;
            dst_row_next   = '0;
            col_start_next = '0;
            first_row_next = 1'b1;
            state_next     = S_CFG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sw_reg        <= DIM_W'(2);
            sh_reg        <= DIM_W'(2);
            ow_reg        <= OW_W'(1);
            oh_reg        <= DIM_W'(1);
            cq_reg        <= DIM_W'(2);
            cr_reg        <= '0;
            rq_reg        <= DIM_W'(2);
            rr_reg        <= '0;
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            dst_col_reg   <= '0;
            dst_row_reg   <= '0;
            col_start_reg <= '0;
            col_edge_reg  <= DIM_W'(2);
            crem_reg      <= '0;
            row_edge_reg  <= DIM_W'(2);
            rrem_reg      <= '0;
            first_row_reg <= 1'b1;
            is_first_reg  <= 1'b0;
            emit_reg      <= 1'b0;
            fend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_fend_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sw_reg        <= sw_next;
            sh_reg        <= sh_next;
            ow_reg        <= ow_next;
            oh_reg        <= oh_next;
            cq_reg        <= cq_next;
            cr_reg        <= cr_next;
            rq_reg        <= rq_next;
            rr_reg        <= rr_next;
            src_col_reg   <= src_col_next;
            src_row_reg   <= src_row_next;
            dst_col_reg   <= dst_col_next;
            dst_row_reg   <= dst_row_next;
            col_start_reg <= col_start_next;
            col_edge_reg  <= col_edge_next;
            crem_reg      <= crem_next;
            row_edge_reg  <= row_edge_next;
            rrem_reg      <= rrem_next;
            first_row_reg <= first_row_next;
            is_first_reg  <= is_first_next;
            emit_reg      <= emit_next;
            fend_reg      <= fend_next;
            out_valid_reg <= out_valid_next;
            out_fend_reg  <= out_fend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        avg_reg <= avg_next;
    end

    bfd_cdiv u_cdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sw_eff),
        .den   (DIM_W'(ow_eff)),
        .quo   (cdiv_q),
        .rem   (cdiv_r),
        .done  (cdiv_done)
    );

    bfd_cdiv u_rdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sh_eff),
        .den   (oh_eff),
        .quo   (rdiv_q),
        .rem   (rdiv_r),
        .done  (rdiv_done)
    );

    bfd_acc u_acc (
        .clk  (clk),
        .ctrl (acc_ctrl),
        .pix  (pix_reg),
        .upd  (acc_upd)
    );

    bfd_mean u_mean (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mean_start),
        .entry (acc_upd),
        .quo   (mean_q),
        .done  (mean_done)
    );

    assign avg.valid     = out_valid_reg;
    assign avg.avg0      = avg_reg[0];
    assign avg.avg1      = avg_reg[1];
    assign avg.avg2      = avg_reg[2];
    assign avg.avg3      = avg_reg[3];
    assign avg.frame_end = out_fend_reg;

    // write-back follows a memory read issued for an accepted request
    a_rmw_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RMW |-> $past(pix.valid && pix.ready))
        else $error("write-back without a preceding request");

    // a result only appears from a finished mean
    a_out_from_mean: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_MEAN))
        else $error("output loaded outside the mean step");

    // the column address stays within the output row
    a_dst_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> (OW_W'(dst_col_reg) < ow_eff))
        else $error("output column beyond output width");

endmodule
